>>> rtl/ipbf_pkg.sv
// Shared types and constants of the source prefix blocklist filter.
package ipbf_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [15:0] TYPE_V4 = 16'h0800;
	localparam logic [15:0] TYPE_V6 = 16'h86DD;
	localparam int ETH_HDR_LEN = 14;
	localparam int V4_MIN_LEN = 34;
	localparam int V6_MIN_LEN = 54;
	localparam logic [7:0] V4_ADDR_BITS = 8'd32;
	localparam logic [7:0] V6_ADDR_BITS = 8'd128;
	localparam logic [5:0] OFFSET_MAX = 6'd63;

	typedef enum logic [1:0] {
		RSN_SHORT_ETH = 2'd0,
		RSN_SHORT_IP  = 2'd1,
		RSN_BLOCKED   = 2'd2,
		RSN_PASS      = 2'd3
	} reason_t;

	typedef enum logic [1:0] {
		JOB_WRITE,
		JOB_VERDICT,
		JOB_LOOKUP
	} job_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} back_state_t;

	// One queued job: a table write, a verdict known up front, or a lookup.
	typedef struct packed {
		job_kind_t   kind;
		reason_t     reason;
		logic        is_v6;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  wr_index;
		logic        wr_valid;
		logic [7:0]  wr_prefix_len;
		logic        wr_blocked;
	} job_t;

	typedef struct packed {
		logic        is_v6;
		logic [7:0]  prefix_len;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic        blocked;
	} tbl_entry_t;

endpackage

>>> rtl/ipbf_if.sv
// Channel interfaces for request items and verdict items.
interface ipbf_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [7:0]  entry_index;
	logic        entry_valid;
	logic        entry_is_v6;
	logic [7:0]  entry_prefix_len;
	logic [63:0] entry_addr_hi;
	logic [63:0] entry_addr_lo;
	logic        entry_blocked;

	modport source (output valid, req_type, data_byte, last_byte, entry_index, entry_valid,
		entry_is_v6, entry_prefix_len, entry_addr_hi, entry_addr_lo, entry_blocked,
		input ready);
	modport sink (input valid, req_type, data_byte, last_byte, entry_index, entry_valid,
		entry_is_v6, entry_prefix_len, entry_addr_hi, entry_addr_lo, entry_blocked,
		output ready);
endinterface

interface ipbf_out_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic [1:0]  reason;
	logic [63:0] drop_total;
	logic [63:0] pass_total;

	modport source (output valid, verdict, reason, drop_total, pass_total, input ready);
	modport sink (input valid, verdict, reason, drop_total, pass_total, output ready);
endinterface

>>> rtl/ipbf_front.sv
// Frame parser: tracks the byte offset, captures EtherType and source, and classifies frames.
module ipbf_front
	import ipbf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	ipbf_in_if.sink req,
	input  logic   q_full,
	output logic   push,
	output job_t   job
);

	logic [5:0]  off_q;
	logic [15:0] etype_q;
	logic [63:0] src_hi_q;
	logic [63:0] src_lo_q;

	logic [5:0]  off_d;
	logic [15:0] et_n;
	logic [63:0] hi_n;
	logic [63:0] lo_n;
	logic        acc;

	assign req.ready = !q_full;
	assign acc = req.valid && req.ready;

	always_comb begin
		logic [2:0] pos;
		pos = '0;
		et_n = (off_q == '0) ? '0 : etype_q;
		hi_n = (off_q == '0) ? '0 : src_hi_q;
		lo_n = (off_q == '0) ? '0 : src_lo_q;
		if (off_q == 6'd12 || off_q == 6'd13) begin
			et_n = {et_n[7:0], req.data_byte};
		end
		if (et_n == TYPE_V4 && off_q inside {[6'd26:6'd29]}) begin
			pos = 3'(off_q - 6'd26);
			hi_n[8 * (7 - pos) +: 8] = req.data_byte;
		end
		if (et_n == TYPE_V6 && off_q inside {[6'd22:6'd29]}) begin
			pos = 3'(off_q - 6'd22);
			hi_n[8 * (7 - pos) +: 8] = req.data_byte;
		end
		if (et_n == TYPE_V6 && off_q inside {[6'd30:6'd37]}) begin
			pos = 3'(off_q - 6'd30);
			lo_n[8 * (7 - pos) +: 8] = req.data_byte;
		end

		if (req.last_byte) begin
			off_d = '0;
		end else if (off_q < OFFSET_MAX) begin
			off_d = off_q + 6'd1;
		end else begin
			off_d = off_q;
		end

		job = '0;
		job.kind = JOB_VERDICT;
		job.reason = RSN_PASS;
		job.addr_hi = hi_n;
		job.addr_lo = lo_n;
		if (req.req_type) begin
			job.kind = JOB_WRITE;
			job.is_v6 = req.entry_is_v6;
			job.addr_hi = req.entry_addr_hi;
			job.addr_lo = req.entry_addr_lo;
			job.wr_index = req.entry_index;
			job.wr_valid = req.entry_valid;
			job.wr_prefix_len = req.entry_prefix_len;
			job.wr_blocked = req.entry_blocked;
		end else if (off_q < 6'(ETH_HDR_LEN - 1)) begin
			job.reason = RSN_SHORT_ETH;
		end else if (et_n == TYPE_V4) begin
			if (off_q < 6'(V4_MIN_LEN - 1)) begin
				job.reason = RSN_SHORT_IP;
			end else begin
				job.kind = JOB_LOOKUP;
			end
		end else if (et_n == TYPE_V6) begin
			job.is_v6 = 1'b1;
			if (off_q < 6'(V6_MIN_LEN - 1)) begin
				job.reason = RSN_SHORT_IP;
			end else begin
				job.kind = JOB_LOOKUP;
			end
		end
	end

	assign push = acc && (req.req_type || req.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			etype_q <= '0;
			src_hi_q <= '0;
			src_lo_q <= '0;
		end else if (acc && !req.req_type) begin
			off_q <= off_d;
			etype_q <= et_n;
			src_hi_q <= hi_n;
			src_lo_q <= lo_n;
		end
	end

endmodule

>>> rtl/ipbf_queue.sv
// Two-entry job queue between the parser and the lookup engine.
module ipbf_queue
	import ipbf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic vld,
	output job_t head,
	input  logic pop
);

	job_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign vld = (cnt_q != 2'd0);
	assign head = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> rtl/ipbf_back.sv
// Lookup engine: owns the prefix table, walks it per lookup, and issues verdict items.
module ipbf_back
	import ipbf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_vld,
	input  job_t    q_job,
	output logic    q_pop,
	ipbf_out_if.source res
);

	tbl_entry_t             mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	back_state_t state_q, state_d;
	logic [IDX_W:0]   walk_q;
	logic [IDX_W-1:0] idx_s1;
	logic             cmp_vld_s1;
	tbl_entry_t       rd_s1;
	logic             job_v6_q;
	logic [63:0]      src_hi_q;
	logic [63:0]      src_lo_q;
	logic             found_q;
	logic [7:0]       best_len_q;
	logic             best_blk_q;

	logic [63:0] drop_q, pass_q;
	logic        res_vld_q;
	logic        res_verdict_q;
	reason_t     res_reason_q;

	logic        room, emit, mem_we, mem_re, start, wr_ok;
	reason_t     emit_reason;
	logic [7:0]  len_c;
	logic [127:0] mask;
	logic        hit, take;
	logic [IDX_W-1:0] wr_addr;

	assign room = !res_vld_q || res.ready;
	assign wr_ok = (32'(q_job.wr_index) < TABLE_ENTRIES);
	assign wr_addr = IDX_W'(q_job.wr_index);

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		emit = 1'b0;
		emit_reason = RSN_PASS;
		mem_we = 1'b0;
		start = 1'b0;
		mem_re = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_vld) begin
					case (q_job.kind)
						JOB_WRITE: begin
							q_pop = 1'b1;
							mem_we = wr_ok;
						end
						JOB_LOOKUP: begin
							q_pop = 1'b1;
							start = 1'b1;
							state_d = ST_WALK;
						end
						default: begin
							if (room) begin
								q_pop = 1'b1;
								emit = 1'b1;
								emit_reason = q_job.reason;
							end
						end
					endcase
				end
			end
			ST_WALK: begin
				mem_re = (32'(walk_q) < TABLE_ENTRIES);
				if (!mem_re && !cmp_vld_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (room) begin
					emit = 1'b1;
					emit_reason = (found_q && best_blk_q) ? RSN_BLOCKED : RSN_PASS;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= '{is_v6: q_job.is_v6, prefix_len: q_job.wr_prefix_len,
				addr_hi: q_job.addr_hi, addr_lo: q_job.addr_lo, blocked: q_job.wr_blocked};
		end
		if (mem_re) begin
			rd_s1 <= mem[walk_q[IDX_W-1:0]];
		end
	end

	always_comb begin
		len_c = rd_s1.prefix_len;
		if (!job_v6_q && len_c > V4_ADDR_BITS) begin
			len_c = V4_ADDR_BITS;
		end else if (len_c > V6_ADDR_BITS) begin
			len_c = V6_ADDR_BITS;
		end
		mask = ~({128{1'b1}} >> len_c);
		hit = cmp_vld_s1 && valid_q[idx_s1] && (rd_s1.is_v6 == job_v6_q)
			&& ((({rd_s1.addr_hi, rd_s1.addr_lo} ^ {src_hi_q, src_lo_q}) & mask) == '0);
		take = hit && (!found_q || len_c > best_len_q);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_v6_q <= q_job.is_v6;
			src_hi_q <= q_job.addr_hi;
			src_lo_q <= q_job.addr_lo;
		end
		idx_s1 <= walk_q[IDX_W-1:0];
		if (take) begin
			best_len_q <= len_c;
			best_blk_q <= rd_s1.blocked;
		end
		if (emit) begin
			res_verdict_q <= (emit_reason == RSN_PASS);
			res_reason_q <= emit_reason;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			walk_q <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			res_vld_q <= 1'b0;
			drop_q <= '0;
			pass_q <= '0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				valid_q[wr_addr] <= q_job.wr_valid;
			end
			cmp_vld_s1 <= mem_re;
			if (start) begin
				walk_q <= '0;
				found_q <= 1'b0;
			end else if (mem_re) begin
				walk_q <= walk_q + (IDX_W + 1)'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (emit) begin
				res_vld_q <= 1'b1;
				if (emit_reason == RSN_SHORT_IP || emit_reason == RSN_BLOCKED) begin
					drop_q <= drop_q + 64'd1;
				end else if (emit_reason == RSN_PASS) begin
					pass_q <= pass_q + 64'd1;
				end
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign res.valid = res_vld_q;
	assign res.verdict = res_verdict_q;
	assign res.reason = res_reason_q;
	assign res.drop_total = drop_q;
	assign res.pass_total = pass_q;

endmodule

>>> rtl/ip_source_prefix_blocklist_filter.sv
// Top level of the source prefix blocklist filter.
//
// Frame bytes and table-entry writes arrive on one channel; each final frame byte yields
// one verdict item with drop/pass, a reason, and running drop and pass totals. A parser
// takes one item per cycle while its two-entry job queue has room, capturing the
// EtherType and the IPv4 or IPv6 source address as bytes go by. Frame ends whose verdict
// is fixed by length or EtherType, and table writes, need no walk in the lookup engine.
// A frame that needs a lookup walks the prefix table through its single memory port, one
// entry per cycle, and the longest match wins; equal lengths keep the lowest index.
// Parsing of the next frame overlaps that walk, and the parser stalls only when two jobs
// already wait. Table writes are applied in arrival order relative to frame ends. The
// verdict sits in an output register, so the engine moves on while a result waits to be
// taken. Entry valid bits clear at reset; no clearing pass is needed.
module ip_source_prefix_blocklist_filter
	import ipbf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ipbf_in_if.sink    req,
	ipbf_out_if.source res
);

	logic push, q_full, q_vld, q_pop;
	job_t push_job, head;

	// Parser and classifier.
	ipbf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	// Decouples parsing from the table walk.
	ipbf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.vld      (q_vld),
		.head     (head),
		.pop      (q_pop)
	);

	// Table owner, lookup walk, counters and result register.
	ipbf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_job  (head),
		.q_pop  (q_pop),
		.res    (res)
	);

endmodule

>>> rtl/ipbf_checker.sv
// Port-level checks of the filter, bound to the top level.
module ipbf_checker
	import ipbf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        verdict,
	input logic [1:0]  reason,
	input logic [63:0] drop_total,
	input logic [63:0] pass_total
);

	logic [63:0] last_drop_q, last_pass_q;
	logic        out_acc;
	logic        counted;

	assign out_acc = out_valid && out_ready;
	assign counted = (reason == RSN_SHORT_IP) || (reason == RSN_BLOCKED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_drop_q <= '0;
			last_pass_q <= '0;
		end else if (out_acc) begin
			last_drop_q <= drop_total;
			last_pass_q <= pass_total;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drop_total) && $stable(pass_total))
		else $error("result changed while stalled");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == (reason == RSN_PASS)))
		else $error("verdict disagrees with reason");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> drop_total == last_drop_q + 64'(counted))
		else $error("drop total stepped wrongly");

	a_pass_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pass_total == last_pass_q + 64'(verdict))
		else $error("pass total stepped wrongly");

endmodule

bind ip_source_prefix_blocklist_filter ipbf_checker u_ipbf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.verdict    (res.verdict),
	.reason     (res.reason),
	.drop_total (res.drop_total),
	.pass_total (res.pass_total)
);

>>> tb/ipbf_checker.sv
// Verdict predictor and scoreboard for the source prefix blocklist filter.
module ipbf_scoreboard
	import ipbf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ipbf_in_if  req,
	ipbf_out_if res,
	output int  fail_count,
	output int  pending_verdicts,
	output int  verdicts_seen
);

	typedef struct packed {
		logic        verdict;
		reason_t     reason;
		logic [63:0] drop_total;
		logic [63:0] pass_total;
	} verdict_t;

	verdict_t expected_verdicts[$];

	logic [5:0]  frame_pos;
	logic [15:0] frame_type;
	logic [63:0] src_hi, src_lo;
	logic [63:0] drops, passes;
	tbl_entry_t  prefix_tbl [TABLE_ENTRIES];
	logic        prefix_live [TABLE_ENTRIES];

	function automatic logic [63:0] top_mask(int n);
		if (n <= 0) return 64'd0;
		if (n >= 64) return '1;
		return ~64'd0 << (64 - n);
	endfunction

	// Longest-prefix match over entries of the frame's family; ties keep the lowest index.
	function automatic logic source_blocked(logic v6);
		logic found;
		logic hit_block;
		int best, n;
		found = 1'b0;
		hit_block = 1'b0;
		best = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (!prefix_live[i] || prefix_tbl[i].is_v6 != v6) continue;
			n = int'(prefix_tbl[i].prefix_len);
			if (!v6 && n > 32) n = 32;
			if (n > 128) n = 128;
			if (((prefix_tbl[i].addr_hi ^ src_hi) & top_mask(n)) != 0) continue;
			if (((prefix_tbl[i].addr_lo ^ src_lo) & top_mask(n - 64)) != 0) continue;
			if (!found || n > best) begin
				found = 1'b1;
				best = n;
				hit_block = prefix_tbl[i].blocked;
			end
		end
		return found && hit_block;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int pos, flen;
		logic [7:0] b;
		verdict_t v, got;
		if (!arst_n) begin
			frame_pos = '0; frame_type = '0; src_hi = '0; src_lo = '0;
			drops = '0; passes = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) prefix_live[i] = 1'b0;
			expected_verdicts.delete();
			fail_count = 0;
			verdicts_seen = 0;
		end else begin
			// Result side first, so a verdict predicted this edge is never compared early.
			if (res.valid && res.ready) begin
				got = '{res.verdict, reason_t'(res.reason), res.drop_total, res.pass_total};
				verdicts_seen++;
				if (expected_verdicts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected verdict item %p", got);
				end else begin
					v = expected_verdicts.pop_front();
					if (got !== v) begin
						fail_count++;
						if (fail_count <= 10) $display("verdict mismatch: exp %p got %p", v, got);
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type) begin
					if (req.entry_index < TABLE_ENTRIES) begin
						prefix_live[req.entry_index] = req.entry_valid;
						prefix_tbl[req.entry_index] = '{req.entry_is_v6, req.entry_prefix_len,
							req.entry_addr_hi, req.entry_addr_lo, req.entry_blocked};
					end
				end else begin
					b = req.data_byte;
					pos = int'(frame_pos);
					if (pos == 0) begin frame_type = '0; src_hi = '0; src_lo = '0; end
					if (pos == 12 || pos == 13) frame_type = {frame_type[7:0], b};
					if (frame_type == TYPE_V4 && pos >= 26 && pos <= 29)
						src_hi[63 - 8*(pos-26) -: 8] = b;
					if (frame_type == TYPE_V6 && pos >= 22 && pos <= 29)
						src_hi[63 - 8*(pos-22) -: 8] = b;
					if (frame_type == TYPE_V6 && pos >= 30 && pos <= 37)
						src_lo[63 - 8*(pos-30) -: 8] = b;
					if (frame_pos < OFFSET_MAX) frame_pos = frame_pos + 6'd1;
					if (req.last_byte) begin
						flen = pos + 1;
						frame_pos = '0;
						v = '{1'b1, RSN_PASS, 64'd0, 64'd0};
						if (flen < ETH_HDR_LEN) begin
							v.verdict = 1'b0; v.reason = RSN_SHORT_ETH;
						end else if (frame_type == TYPE_V4 || frame_type == TYPE_V6) begin
							if (flen < ((frame_type == TYPE_V6) ? V6_MIN_LEN : V4_MIN_LEN)) begin
								v.verdict = 1'b0; v.reason = RSN_SHORT_IP;
							end else if (source_blocked(frame_type == TYPE_V6)) begin
								v.verdict = 1'b0; v.reason = RSN_BLOCKED;
							end
						end
						if (v.reason == RSN_SHORT_IP || v.reason == RSN_BLOCKED) drops++;
						else if (v.verdict) passes++;
						v.drop_total = drops;
						v.pass_total = passes;
						expected_verdicts.push_back(v);
					end
				end
			end
		end
		pending_verdicts = expected_verdicts.size();
	end

	final if (expected_verdicts.size() != 0)
		$display("%0d verdicts never arrived", expected_verdicts.size());

endmodule

>>> tb/ip_source_prefix_blocklist_filter_test.sv
// Stimulus and verdict of the source prefix blocklist filter test.
module ip_source_prefix_blocklist_filter_test;
	import ipbf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending_verdicts, verdicts_seen;
	int cycle_count = 0;
	int items_sent = 0;
	int frames_sent = 0;
	int writes_sent = 0;
	int long_hold = 0;
	bit hold_done = 0;
	bit stim_done = 0;

	ipbf_in_if  req ();
	ipbf_out_if res ();

	ip_source_prefix_blocklist_filter uut (.clk(clk), .arst_n(arst_n), .req(req), .res(res));

	ipbf_scoreboard check (.clk(clk), .arst_n(arst_n), .req(req), .res(res),
		.fail_count(fail_count), .pending_verdicts(pending_verdicts),
		.verdicts_seen(verdicts_seen));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A small pool of addresses is shared by table entries and frame sources, so
	// lookups often hit, sometimes at several prefix lengths at once.
	logic [127:0] addr_pool [8];

	// Gap lengths: mostly zero or short, now and then a long stretch.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one item: hold valid until the block takes it, then maybe idle.
	task automatic send_item(logic rt, logic [7:0] db, logic lb, logic [7:0] idx, logic ev,
			logic e6, logic [7:0] plen, logic [63:0] ahi, logic [63:0] alo, logic blk);
		int idle;
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.data_byte <= db;
		req.last_byte <= lb;
		req.entry_index <= idx;
		req.entry_valid <= ev;
		req.entry_is_v6 <= e6;
		req.entry_prefix_len <= plen;
		req.entry_addr_hi <= ahi;
		req.entry_addr_lo <= alo;
		req.entry_blocked <= blk;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
		// Keep valid high straight into the next item when no gap follows.
		idle = gap_len();
		if (idle > 0) begin
			req.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
	endtask

	task automatic write_entry(logic [7:0] idx, logic ev, logic e6, logic [7:0] plen,
			logic [127:0] a, logic blk);
		writes_sent++;
		send_item(1'b1, 8'($urandom), 1'($urandom), idx, ev, e6, plen, a[127:64], a[63:0],
			blk);
	endtask

	// A frame of flen bytes with the given EtherType and source address; the
	// other bytes are random. A table write may be slipped in mid-frame.
	task automatic send_frame(int flen, logic [15:0] etype, logic [127:0] src, bit mid_write);
		logic [7:0] b;
		frames_sent++;
		for (int p = 0; p < flen; p++) begin
			b = 8'($urandom);
			if (p == 12) b = etype[15:8];
			if (p == 13) b = etype[7:0];
			if (etype == TYPE_V4 && p >= 26 && p <= 29) b = src[127 - 8*(p-26) -: 8];
			if (etype == TYPE_V6 && p >= 22 && p <= 37) b = src[127 - 8*(p-22) -: 8];
			send_item(1'b0, b, p == flen - 1, 8'($urandom), 1'($urandom), 1'($urandom),
				8'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
			if (mid_write && p == flen / 2)
				write_entry(8'($urandom), 1'($urandom), 1'($urandom),
					8'($urandom_range(0, 255)), addr_pool[$urandom_range(0, 7)],
					1'($urandom));
		end
	endtask

	function automatic logic [15:0] pick_type();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return TYPE_V4;
		if (r < 8) return TYPE_V6;
		return 16'($urandom);
	endfunction

	function automatic int pick_len(logic [15:0] t);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom_range(1, 13);
		if (r == 1) return $urandom_range(14, (t == TYPE_V6) ? 53 : 33);
		if (r == 2) return $urandom_range(54, 90);
		return (t == TYPE_V6) ? $urandom_range(54, 60) : $urandom_range(34, 40);
	endfunction

	// Random address near a pool member: random low bits below a random point.
	function automatic logic [127:0] near_pool();
		logic [127:0] a, noise;
		int keep;
		a = addr_pool[$urandom_range(0, 7)];
		keep = $urandom_range(0, 128);
		noise = {$urandom, $urandom, $urandom, $urandom};
		if (keep < 128) a = (a & ~(~128'd0 >> keep)) | (noise & (~128'd0 >> keep));
		return a;
	endfunction

	// Receiver: random stalls, plus one long hold-off while frames keep coming.
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && frames_sent > 40) begin
				res.ready <= 1'b0;
				while (long_hold < 400) begin
					@(posedge clk);
					long_hold++;
				end
				hold_done = 1;
			end else if ($urandom_range(0, 29) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				res.ready <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	// Run limit, generous against the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [127:0] a;
		logic [15:0] t;
		int settle;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.data_byte = '0;
		req.last_byte = 1'b0;
		req.entry_index = '0;
		req.entry_valid = 1'b0;
		req.entry_is_v6 = 1'b0;
		req.entry_prefix_len = '0;
		req.entry_addr_hi = '0;
		req.entry_addr_lo = '0;
		req.entry_blocked = 1'b0;
		for (int i = 0; i < 8; i++)
			addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
		addr_pool[0] = '1;
		addr_pool[1] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-table lookups, short and odd frames, field extremes.
		send_frame(34, TYPE_V4, addr_pool[0], 1'b0);
		send_frame(1, TYPE_V4, '0, 1'b0);
		send_frame(13, TYPE_V4, '0, 1'b0);
		send_frame(14, 16'h1234, '0, 1'b0);
		send_frame(33, TYPE_V4, '0, 1'b0);
		send_frame(53, TYPE_V6, '0, 1'b0);
		send_frame(70, TYPE_V6, addr_pool[0], 1'b0);
		// Blocked /8, longer pass /16 overrides it; equal-length tie goes to low index.
		write_entry(8'd0, 1'b1, 1'b0, 8'd8, addr_pool[0], 1'b1);
		write_entry(8'd5, 1'b1, 1'b0, 8'd16, addr_pool[0], 1'b0);
		write_entry(8'd3, 1'b1, 1'b0, 8'd16, addr_pool[0], 1'b1);
		send_frame(34, TYPE_V4, addr_pool[0], 1'b0);
		write_entry(8'd3, 1'b0, 1'b0, 8'd16, addr_pool[0], 1'b1);
		send_frame(40, TYPE_V4, addr_pool[0], 1'b0);
		// Oversized prefixes clamp; zero length matches every address of its family.
		write_entry(8'd255, 1'b1, 1'b0, 8'd200, addr_pool[1], 1'b1);
		write_entry(8'd254, 1'b1, 1'b1, 8'd255, addr_pool[0], 1'b1);
		write_entry(8'd253, 1'b1, 1'b1, 8'd0, addr_pool[1], 1'b0);
		send_frame(34, TYPE_V4, addr_pool[1], 1'b1);
		send_frame(54, TYPE_V6, addr_pool[0], 1'b0);
		send_frame(54, TYPE_V6, addr_pool[1], 1'b0);
		send_frame(63, 16'h0000, '0, 1'b0);
		send_frame(64, 16'hFFFF, '1, 1'b0);

		// Random part: table churn and frames aimed at the pooled addresses.
		while (items_sent < 1450) begin
			if ($urandom_range(0, 3) == 0) begin
				a = near_pool();
				write_entry(8'($urandom), $urandom_range(0, 5) != 0, 1'($urandom),
					8'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 128)),
					($urandom_range(0, 1) != 0) ? addr_pool[$urandom_range(0, 7)] : a,
					1'($urandom));
			end else begin
				t = pick_type();
				a = near_pool();
				send_frame(pick_len(t), t, a, $urandom_range(0, 9) == 0);
			end
		end
		req.valid <= 1'b0;
		stim_done = 1;

		// Drain: wait for outstanding verdicts, then quiet time scaled to the table size.
		while (pending_verdicts != 0) @(posedge clk);
		settle = 0;
		while (settle < 4 * (TABLE_ENTRIES + 8)) begin
			@(posedge clk);
			settle++;
		end
		$display("sent %0d items: %0d frames, %0d table writes; %0d verdicts checked",
			items_sent, frames_sent, writes_sent, verdicts_seen);
		$display("receiver long hold-off %0d cycles, run length %0d cycles",
			long_hold, cycle_count);
		if (fail_count == 0 && pending_verdicts == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
